// File: design/wmrq_pkg.sv
// Shared constants, types and the control store for the window mean block.
package wmrq_pkg;

    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int WINDOW_SIZE = 9;
    localparam int RADIUS      = WINDOW_SIZE / 2;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // coordinates, frame sizes and clipped bounds
    localparam int DIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT)
                                  + (1 << COL_W) + RADIUS + 1);
    localparam int CNT_W = $clog2(WINDOW_SIZE * WINDOW_SIZE + 1);
    localparam int SUM_W = $clog2(WINDOW_SIZE * WINDOW_SIZE * 255 + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // microprogram
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] step_t;

    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_CHECK   = 4'd1;
    localparam step_t STEP_SETUP   = 4'd2;
    localparam step_t STEP_READ    = 4'd3;
    localparam step_t STEP_CENTER  = 4'd4;
    localparam step_t STEP_DIVGO   = 4'd5;
    localparam step_t STEP_DIVWAIT = 4'd6;
    localparam step_t STEP_EMIT    = 4'd7;
    localparam step_t STEP_ERR     = 4'd8;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_QUERY,
        COND_ERR,
        COND_MORE,
        COND_DIV_BUSY
    } cond_t;

    typedef struct packed {
        logic  setup;
        logic  rd_win;
        logic  rd_ctr;
        logic  div_go;
        logic  emit;
        logic  emit_err;
        cond_t cond;
        step_t target;
    } ucode_t;

    // jump to target when cond holds, else fall through to the next step
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t uc;
        uc = '{setup: 1'b0, rd_win: 1'b0, rd_ctr: 1'b0, div_go: 1'b0, emit: 1'b0,
               emit_err: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:
            begin
                uc.cond   = COND_NO_QUERY;
                uc.target = STEP_IDLE;
            end
            STEP_CHECK:
            begin
                uc.cond   = COND_ERR;
                uc.target = STEP_ERR;
            end
            STEP_SETUP:
            begin
                uc.setup = 1'b1;
                uc.cond  = COND_NEVER;
            end
            STEP_READ:
            begin
                uc.rd_win = 1'b1;
                uc.cond   = COND_MORE;
                uc.target = STEP_READ;
            end
            STEP_CENTER:
            begin
                uc.rd_ctr = 1'b1;
                uc.cond   = COND_NEVER;
            end
            STEP_DIVGO:
            begin
                uc.div_go = 1'b1;
                uc.cond   = COND_NEVER;
            end
            STEP_DIVWAIT:
            begin
                uc.cond   = COND_DIV_BUSY;
                uc.target = STEP_DIVWAIT;
            end
            STEP_EMIT:
            begin
                uc.emit = 1'b1;
            end
            STEP_ERR:
            begin
                uc.emit_err = 1'b1;
            end
            default:
            begin
                uc.cond = COND_ALWAYS;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: design/wmrq_ram.sv
// Generic simple dual-port RAM with registered read.
module wmrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/wmrq_div.sv
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
module wmrq_div
    import wmrq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2:0][SUM_W-1:0]      dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       busy,
    output logic [2:0][SUM_W-1:0]      quotient
);

    localparam int BITS_W = $clog2(SUM_W + 1);

    logic                  busy_reg;
    logic [BITS_W-1:0]     bits_reg;
    logic [CNT_W-1:0]      dvsr_reg;
    logic [2:0][SUM_W-1:0] quo_reg;
    logic [2:0][CNT_W-1:0] rem_reg;
    logic [2:0][CNT_W:0]   trial;
    logic [2:0]            fits;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {rem_reg[i], quo_reg[i][SUM_W-1]};
            fits[i]  = (trial[i] >= {1'b0, dvsr_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bits_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            bits_reg <= BITS_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            bits_reg <= bits_reg - 1'b1;
            if (bits_reg == BITS_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvsr_reg <= divisor;
            quo_reg  <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (fits[i])
                begin
                    rem_reg[i] <= CNT_W'(trial[i] - {1'b0, dvsr_reg});
                end
                else
                begin
                    rem_reg[i] <= CNT_W'(trial[i]);
                end
                quo_reg[i] <= {quo_reg[i][SUM_W-2:0], fits[i]};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: design/window_mean_rgb_query.sv
// Top level: 9x9 clipped window mean over a stored RGB frame, microcoded control.
// Load beat: written to the pixel RAM at the accepting edge, no result.
// Query beat: done rises after the check, setup, one RAM read per window pixel, the centre
// read, the bit-serial divider over the SUM_W = 15 bits of each sum, and the emit step.
// A query outside the frame goes from the check straight to the error step.
// A new beat is taken in the cycle done is high. Reset: frame 640 x 480, RAM not cleared.
module window_mean_rgb_query
    import wmrq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [COL_W-1:0]     col,
    input  logic [ROW_W-1:0]     row,
    input  logic [CHAN_W-1:0]    blue_in,
    input  logic [CHAN_W-1:0]    green_in,
    input  logic [CHAN_W-1:0]    red_in,
    // register writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // result beat, valid for the single cycle done is high
    output logic                 done,
    output logic [CHAN_W-1:0]    center_blue,
    output logic [CHAN_W-1:0]    center_green,
    output logic [CHAN_W-1:0]    center_red,
    output logic [CHAN_W-1:0]    mean_blue,
    output logic [CHAN_W-1:0]    mean_green,
    output logic [CHAN_W-1:0]    mean_red,
    output logic [CNT_OUT_W-1:0] pixels_counted,
    output logic                 coord_error
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COL_W-1:0] image_width_reg;
    logic [ROW_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= COL_W'(640);
            image_height_reg <= ROW_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[COL_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame size saturated to the store dimensions.
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;

    assign frame_w = (DIM_W'(image_width_reg) > DIM_W'(MAX_WIDTH))
                   ? DIM_W'(MAX_WIDTH) : DIM_W'(image_width_reg);
    assign frame_h = (DIM_W'(image_height_reg) > DIM_W'(MAX_HEIGHT))
                   ? DIM_W'(MAX_HEIGHT) : DIM_W'(image_height_reg);

    // ------------------------------------------------------------------
    // Sequencer: step counter plus control store
    // ------------------------------------------------------------------
    step_t  pc_reg;
    step_t  pc_next;
    ucode_t uc;
    logic   take;
    logic   query_acc;
    logic   load_acc;
    logic   coord_err;
    logic   more;
    logic   div_busy;

    assign uc        = ucode_rom(pc_reg);
    assign busy      = (pc_reg != STEP_IDLE);
    assign query_acc = start && !busy && mode;
    assign load_acc  = start && !busy && !mode;

    always_comb
    begin
        case (uc.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_QUERY: take = !query_acc;
            COND_ERR:      take = coord_err;
            COND_MORE:     take = more;
            COND_DIV_BUSY: take = div_busy;
            default:       take = 1'b0;
        endcase
        pc_next = take ? uc.target : step_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // ------------------------------------------------------------------
    // Query coordinate and window bounds
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [DIM_W-1:0]  col_x;
    logic [DIM_W-1:0]  row_x;
    logic [DIM_W-1:0]  r_lo;
    logic [DIM_W-1:0]  r_hi;
    logic [DIM_W-1:0]  c_lo;
    logic [DIM_W-1:0]  c_hi;
    logic [DIM_W-1:0]  r_cur_reg;
    logic [DIM_W-1:0]  r_end_reg;
    logic [DIM_W-1:0]  c_cur_reg;
    logic [DIM_W-1:0]  c_beg_reg;
    logic [DIM_W-1:0]  c_end_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic              row_last;
    logic              col_last;

    assign col_x     = DIM_W'(col_reg);
    assign row_x     = DIM_W'(row_reg);
    assign coord_err = (col_x >= frame_w) || (row_x >= frame_h);

    // Clip the window to the frame; the centre is known to be inside here.
    assign r_lo = (row_x >= DIM_W'(RADIUS)) ? row_x - DIM_W'(RADIUS) : '0;
    assign r_hi = (row_x + DIM_W'(RADIUS) < frame_h) ? row_x + DIM_W'(RADIUS)
                                                     : frame_h - 1'b1;
    assign c_lo = (col_x >= DIM_W'(RADIUS)) ? col_x - DIM_W'(RADIUS) : '0;
    assign c_hi = (col_x + DIM_W'(RADIUS) < frame_w) ? col_x + DIM_W'(RADIUS)
                                                     : frame_w - 1'b1;

    assign col_last = (c_cur_reg == c_end_reg);
    assign row_last = (r_cur_reg == r_end_reg);
    assign more     = !(col_last && row_last);

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        if (uc.setup)
        begin
            r_cur_reg    <= r_lo;
            r_end_reg    <= r_hi;
            c_cur_reg    <= c_lo;
            c_beg_reg    <= c_lo;
            c_end_reg    <= c_hi;
            row_base_reg <= ADDR_W'(r_lo) * ADDR_W'(MAX_WIDTH);
        end
        else if (uc.rd_win)
        begin
            // raster walk: next column, or wrap to the start of the next row
            if (col_last)
            begin
                c_cur_reg <= c_beg_reg;
                if (!row_last)
                begin
                    r_cur_reg    <= r_cur_reg + 1'b1;
                    row_base_reg <= row_base_reg + ADDR_W'(MAX_WIDTH);
                end
            end
            else
            begin
                c_cur_reg <= c_cur_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel RAM: load beats write, the sequencer reads
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // Loads outside the store are dropped; loads outside the frame are kept.
    assign ram_we    = load_acc && (DIM_W'(col) < DIM_W'(MAX_WIDTH))
                                && (DIM_W'(row) < DIM_W'(MAX_HEIGHT));
    assign ram_waddr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    assign ram_raddr = uc.rd_ctr ? ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg)
                                 : row_base_reg + ADDR_W'(c_cur_reg);

    wmrq_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({red_in, green_in, blue_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Accumulation: RAM data lands in the cycle after each window read
    // ------------------------------------------------------------------
    logic                  pend_reg;
    logic [2:0][SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]      cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= uc.rd_win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.setup)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (uc.rd_win)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (pend_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(ram_rdata[i*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Centre capture and division by the pixel count
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]      center_reg;
    logic [2:0][SUM_W-1:0] quotient;

    always_ff @(posedge clk)
    begin
        if (uc.div_go)
        begin
            center_reg <= ram_rdata;
        end
    end

    wmrq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (uc.div_go),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // Result registers
    // ------------------------------------------------------------------
    logic                 done_reg;
    logic [CHAN_W-1:0]    center_blue_reg;
    logic [CHAN_W-1:0]    center_green_reg;
    logic [CHAN_W-1:0]    center_red_reg;
    logic [CHAN_W-1:0]    mean_blue_reg;
    logic [CHAN_W-1:0]    mean_green_reg;
    logic [CHAN_W-1:0]    mean_red_reg;
    logic [CNT_OUT_W-1:0] pixels_counted_reg;
    logic                 coord_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= uc.emit || uc.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.emit)
        begin
            center_blue_reg    <= center_reg[0*CHAN_W +: CHAN_W];
            center_green_reg   <= center_reg[1*CHAN_W +: CHAN_W];
            center_red_reg     <= center_reg[2*CHAN_W +: CHAN_W];
            mean_blue_reg      <= quotient[0][CHAN_W-1:0];
            mean_green_reg     <= quotient[1][CHAN_W-1:0];
            mean_red_reg       <= quotient[2][CHAN_W-1:0];
            pixels_counted_reg <= CNT_OUT_W'(cnt_reg);
            coord_error_reg    <= 1'b0;
        end
        else if (uc.emit_err)
        begin
            center_blue_reg    <= '0;
            center_green_reg   <= '0;
            center_red_reg     <= '0;
            mean_blue_reg      <= '0;
            mean_green_reg     <= '0;
            mean_red_reg       <= '0;
            pixels_counted_reg <= '0;
            coord_error_reg    <= 1'b1;
        end
    end

    assign done           = done_reg;
    assign center_blue    = center_blue_reg;
    assign center_green   = center_green_reg;
    assign center_red     = center_red_reg;
    assign mean_blue      = mean_blue_reg;
    assign mean_green     = mean_green_reg;
    assign mean_red       = mean_red_reg;
    assign pixels_counted = pixels_counted_reg;
    assign coord_error    = coord_error_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a result beat only follows one of the two emitting steps
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(pc_reg) == STEP_EMIT || $past(pc_reg) == STEP_ERR))
        else $error("result beat without an emitting step");

    // the raster walk never leaves its clipped window
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_READ) |-> (c_cur_reg <= c_end_reg && r_cur_reg <= r_end_reg))
        else $error("window walk out of bounds");

    // an error beat carries no count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && coord_error) |-> (pixels_counted == '0))
        else $error("error beat with nonzero count");
`endif

endmodule
